[design/bscc_pkg.sv]
package bscc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PT_PRESENT     = 3'd0,
    REG_CT_PRESENT     = 3'd1,
    REG_BAT_CUT        = 3'd2,
    REG_BAT_RESUME     = 3'd3,
    REG_FLOAT_LIMIT    = 3'd4,
    REG_ACT_LIMIT      = 3'd5,
    REG_ACT_DISCH_END  = 3'd6,
    REG_ACT_CHG_SECS   = 3'd7
  } reg_index_t;

  // input commands; the unused code acts as a plain sample
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  // activation phases
  typedef enum logic [1:0] {
    PH_NORMAL    = 2'd0,
    PH_START     = 2'd1,
    PH_DISCHARGE = 2'd2,
    PH_CHARGE    = 2'd3
  } phase_t;

  // charger routing
  localparam logic [1:0] PATH_OFF = 2'd0;
  localparam logic [1:0] PATH_PT  = 2'd1;
  localparam logic [1:0] PATH_CT  = 2'd2;

  // battery led modes
  localparam logic [1:0] LED_OFF   = 2'd0;
  localparam logic [1:0] LED_ON    = 2'd1;
  localparam logic [1:0] LED_BLINK = 2'd2;

  // register reset values
  localparam logic [11:0] RST_PT_PRESENT    = 12'd450;
  localparam logic [11:0] RST_CT_PRESENT    = 12'd1488;
  localparam logic [11:0] RST_BAT_CUT       = 12'd1080;
  localparam logic [11:0] RST_BAT_RESUME    = 12'd1150;
  localparam logic [11:0] RST_FLOAT_LIMIT   = 12'd1420;
  localparam logic [11:0] RST_ACT_LIMIT     = 12'd1480;
  localparam logic [11:0] RST_ACT_DISCH_END = 12'd800;
  localparam logic [16:0] RST_ACT_CHG_SECS  = 17'd86400;

  localparam int CFG_DATA_W = 17;

  typedef struct packed {
    logic [11:0] pt_present_threshold;
    logic [11:0] ct_present_threshold;
    logic [11:0] battery_cut_level;
    logic [11:0] battery_resume_level;
    logic [11:0] float_charge_limit;
    logic [11:0] activation_charge_limit;
    logic [11:0] activation_discharge_end;
    logic [16:0] activation_charge_seconds;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] pt_voltage;
    logic [11:0] ct_voltage;
    logic [11:0] battery_voltage;
    logic [31:0] now_seconds;
  } in_word_t;

  typedef struct packed {
    logic       rail_power_off;
    logic       battery_rail_switch;
    logic       radio_cut;
    logic       supply_restored;
    logic [1:0] charge_path;
    logic [7:0] charge_duty;
    logic       charge_led_blink;
    logic       activation_led_blink;
    logic [1:0] battery_led_mode;
    logic       discharge_load_on;
    logic [1:0] activation_phase;
    logic       activation_done;
  } out_word_t;

  // controller state carried from word to word (duty kept apart, its width varies)
  typedef struct packed {
    logic        rail_off_flag;
    logic        rail_switch_on;
    phase_t      phase;
    logic        load_on;
    logic        timer_armed;
    logic [31:0] charge_start_second;
  } state_t;

endpackage

[design/bscc_cfg.sv]
module bscc_cfg
  import bscc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [2:0]            wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  // register file with reset defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pt_present_threshold      <= RST_PT_PRESENT;
      cfg.ct_present_threshold      <= RST_CT_PRESENT;
      cfg.battery_cut_level         <= RST_BAT_CUT;
      cfg.battery_resume_level      <= RST_BAT_RESUME;
      cfg.float_charge_limit        <= RST_FLOAT_LIMIT;
      cfg.activation_charge_limit   <= RST_ACT_LIMIT;
      cfg.activation_discharge_end  <= RST_ACT_DISCH_END;
      cfg.activation_charge_seconds <= RST_ACT_CHG_SECS;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PT_PRESENT:    cfg.pt_present_threshold      <= wr_data[11:0];
        REG_CT_PRESENT:    cfg.ct_present_threshold      <= wr_data[11:0];
        REG_BAT_CUT:       cfg.battery_cut_level         <= wr_data[11:0];
        REG_BAT_RESUME:    cfg.battery_resume_level      <= wr_data[11:0];
        REG_FLOAT_LIMIT:   cfg.float_charge_limit        <= wr_data[11:0];
        REG_ACT_LIMIT:     cfg.activation_charge_limit   <= wr_data[11:0];
        REG_ACT_DISCH_END: cfg.activation_discharge_end  <= wr_data[11:0];
        REG_ACT_CHG_SECS:  cfg.activation_charge_seconds <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

[design/bscc_step.sv]
module bscc_step
  import bscc_pkg::*;
#(
  parameter int MAX_DUTY = 255,
  parameter int DUTY_W   = $clog2(MAX_DUTY + 1)
)
(
  input  cfg_t              cfg,
  input  in_word_t          in_word,
  input  state_t            state,
  input  logic [DUTY_W-1:0] duty,
  output state_t            state_next,
  output logic [DUTY_W-1:0] duty_next,
  output out_word_t         out_word
);

  localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(MAX_DUTY);

  logic        pt_ok;
  logic        ct_ok;
  logic        bat_below_cut;
  logic        bat_healthy;
  logic        pwm_run;
  logic [11:0] pwm_limit;
  logic [31:0] start_sec;
  logic [31:0] elapsed;
  logic [31:0] duty_wide;
  phase_t      ph;

  assign pt_ok         = in_word.pt_voltage >= cfg.pt_present_threshold;
  assign ct_ok         = in_word.ct_voltage >= cfg.ct_present_threshold;
  assign bat_below_cut = in_word.battery_voltage < cfg.battery_cut_level;
  assign bat_healthy   = in_word.battery_voltage >= cfg.battery_resume_level;

  // activation charge timer
  assign start_sec = state.timer_armed ? state.charge_start_second : in_word.now_seconds;
  assign elapsed   = in_word.now_seconds - start_sec;

  // rail selection, monitoring and phase sequencing
  always_comb begin
    state_next = state;
    out_word   = '0;
    pwm_run    = 1'b0;
    pwm_limit  = cfg.float_charge_limit;

    // command overrides the phase before the pass
    ph = state.phase;
    if (in_word.command == CMD_START) begin
      ph = PH_START;
    end else if (in_word.command == CMD_CANCEL) begin
      ph = PH_NORMAL;
    end

    // signal rail feed with battery hysteresis
    if (pt_ok) begin
      state_next.rail_switch_on = 1'b0;
      state_next.rail_off_flag  = 1'b0;
    end else if (ct_ok) begin
      state_next.rail_switch_on = 1'b1;
      state_next.rail_off_flag  = 1'b0;
    end else if (bat_below_cut) begin
      state_next.rail_off_flag  = 1'b1;
      state_next.rail_switch_on = 1'b0;
      out_word.radio_cut        = 1'b1;
    end else if (bat_healthy) begin
      state_next.rail_switch_on = 1'b1;
      state_next.rail_off_flag  = 1'b0;
    end
    out_word.supply_restored = (in_word.pt_voltage > cfg.pt_present_threshold) ||
                               (in_word.ct_voltage > cfg.ct_present_threshold);

    // loss of both supplies aborts activation
    if (!pt_ok && !ct_ok) begin
      ph                 = PH_NORMAL;
      state_next.load_on = 1'b0;
    end
    out_word.activation_led_blink = ph != PH_NORMAL;

    if (bat_healthy) begin
      out_word.battery_led_mode = LED_ON;
    end else if (!bat_below_cut) begin
      out_word.battery_led_mode = LED_BLINK;
    end else begin
      out_word.battery_led_mode = LED_OFF;
    end

    unique case (ph)
      PH_START: begin
        state_next.load_on = 1'b1;
        ph                 = PH_DISCHARGE;
      end
      PH_DISCHARGE: begin
        if (in_word.battery_voltage < cfg.activation_discharge_end) begin
          state_next.load_on = 1'b0;
          ph                 = PH_CHARGE;
        end
      end
      PH_CHARGE: begin
        state_next.charge_start_second = start_sec;
        state_next.timer_armed         = 1'b1;
        if (in_word.battery_voltage >= cfg.activation_charge_limit ||
            elapsed >= {15'd0, cfg.activation_charge_seconds}) begin
          state_next.timer_armed   = 1'b0;
          ph                       = PH_NORMAL;
          out_word.activation_done = 1'b1;
        end else begin
          pwm_run   = 1'b1;
          pwm_limit = cfg.activation_charge_limit;
        end
      end
      default: begin
        pwm_run = 1'b1;
      end
    endcase
    state_next.phase = ph;

    // pwm duty ramp toward the active limit
    duty_next = duty;
    if (pwm_run) begin
      if (in_word.battery_voltage < pwm_limit) begin
        duty_next = (duty < DUTY_MAX) ? duty + 1'b1 : DUTY_MAX;
      end else if (in_word.battery_voltage > pwm_limit) begin
        if (duty != '0) begin
          duty_next = duty - 1'b1;
        end
      end
    end

    // charger routing
    if (pwm_run && pt_ok) begin
      out_word.charge_path      = PATH_PT;
      out_word.charge_led_blink = duty_next != '0;
    end else if (pwm_run && ct_ok) begin
      out_word.charge_path      = PATH_CT;
      out_word.charge_led_blink = duty_next != '0;
    end else begin
      out_word.charge_path      = PATH_OFF;
      out_word.charge_led_blink = 1'b0;
    end

    duty_wide                  = 32'(duty_next);
    out_word.charge_duty       = (duty_wide > 32'd255) ? 8'hFF : duty_wide[7:0];
    out_word.rail_power_off    = state_next.rail_off_flag;
    out_word.battery_rail_switch = state_next.rail_switch_on;
    out_word.discharge_load_on = state_next.load_on;
    out_word.activation_phase  = ph;
  end

endmodule

[design/battery_supply_charge_controller_core.sv]
// Battery and supply charge controller core.
// Input channel (in_valid/in_ready/in_word) takes one monitoring sample per
// word: command, PT/CT/battery voltages and a seconds timestamp. The output
// channel (out_valid/out_ready/out_word) returns exactly one result word per
// input word, in order.
// Configuration registers are written on the cfg channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data); cfg_ready is always high. Write them only
// while no sample is in flight.
// A word accepted into the input register passes through the combinational
// state update into the result register, which drives out_word. Throughput:
// one word per cycle while the receiver keeps out_ready high.
// When the receiver stalls, the result register holds its word and the input
// register holds one more; in_ready drops only when both are full.
// Synchronous reset restores register defaults, rail off, phase normal,
// duty zero and timer disarmed, and empties both registers.
module battery_supply_charge_controller_core
  import bscc_pkg::*;
#(
  parameter int MAX_DUTY = 255
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DUTY_W = $clog2(MAX_DUTY + 1);

  cfg_t              cfg;
  in_word_t          in_q;
  logic              in_q_valid;
  out_word_t         out_q;
  logic              out_q_valid;
  state_t            state;
  state_t            state_next;
  logic [DUTY_W-1:0] duty;
  logic [DUTY_W-1:0] duty_next;
  out_word_t         result;
  logic              advance;

  assign cfg_ready = 1'b1;

  bscc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bscc_step #(
    .MAX_DUTY (MAX_DUTY),
    .DUTY_W   (DUTY_W)
  ) u_step (
    .cfg        (cfg),
    .in_word    (in_q),
    .state      (state),
    .duty       (duty),
    .state_next (state_next),
    .duty_next  (duty_next),
    .out_word   (result)
  );

  // handshake
  assign advance   = in_q_valid && (!out_q_valid || out_ready);
  assign in_ready  = !in_q_valid || advance;
  assign out_valid = out_q_valid;
  assign out_word  = out_q;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_word;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_q_valid <= 1'b0;
    end else if (advance) begin
      out_q_valid <= 1'b1;
    end else if (out_ready) begin
      out_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= result;
    end
  end

  // controller state commits as each word moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.rail_off_flag       <= 1'b1;
      state.rail_switch_on      <= 1'b0;
      state.phase               <= PH_NORMAL;
      state.load_on             <= 1'b0;
      state.timer_armed         <= 1'b0;
      state.charge_start_second <= '0;
      duty                      <= '0;
    end else if (advance) begin
      state <= state_next;
      duty  <= duty_next;
    end
  end

  // a stalled result keeps the pending input word in place
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && out_q_valid && !out_ready |=> in_q_valid)
    else $error("pending input word lost during stall");

  // duty never passes its ceiling
  a_duty_max: assert property (@(posedge clk) disable iff (rst)
    32'(duty) <= MAX_DUTY)
    else $error("duty above maximum");

  // the rail is never both off and switched to battery
  a_rail_consistent: assert property (@(posedge clk) disable iff (rst)
    !(state.rail_off_flag && state.rail_switch_on))
    else $error("rail off with switch on");

  // completion of activation returns to the normal phase
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    out_q_valid && out_q.activation_done |-> out_q.activation_phase == PH_NORMAL)
    else $error("activation done outside normal phase");

endmodule
